@@ src/pfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants of the periodic frame scheduler
// Slot count, field widths, operation codes and the result record.
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int NUM_SLOTS = 10;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 16;

	localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sh7FFF;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_POLL = 2'd1,
		OP_ACK  = 2'd2,
		OP_LOAD = 2'd3
	} op_t;

	// one result of a poll
	typedef struct packed {
		logic [SLOT_W-1:0] due_slot;
		logic              due_valid;
		logic              last_of_run;
	} result_t;

	// verdict of the shared slot unit
	typedef struct packed {
		logic                    due;
		logic                    wr_en;
		logic signed [CNT_W-1:0] next_count;
	} alu_res_t;

endpackage

@@ src/pfs_alu.sv @@
// ----------------------------------------------------------------------------
// pfs_alu: shared slot arithmetic unit
// Due test, saturating increment on tick, interval subtraction on ack.
// ----------------------------------------------------------------------------
module pfs_alu (
	input  pfs_pkg::op_t                    op,
	input  logic                            loaded,
	input  logic [pfs_pkg::CNT_W-1:0]       interval,
	input  logic signed [pfs_pkg::CNT_W-1:0] count,
	output pfs_pkg::alu_res_t               res
);

	logic signed [pfs_pkg::CNT_W:0] interval_ext;
	logic signed [pfs_pkg::CNT_W:0] count_ext;
	logic signed [pfs_pkg::CNT_W:0] operand;
	logic signed [pfs_pkg::CNT_W:0] sum;
	logic                           is_tick;

	// single adder, operand is +1 on tick and -interval on ack
	assign is_tick      = (op == pfs_pkg::OP_TICK);
	assign interval_ext = $signed({1'b0, interval});
	assign count_ext    = {count[pfs_pkg::CNT_W-1], count};
	assign operand      = is_tick ? 17'sd1 : -interval_ext;
	assign sum          = count_ext + operand;

	always_comb begin
		res.due        = loaded && (interval_ext <= count_ext);
		res.next_count = sum[pfs_pkg::CNT_W-1:0];
		unique case (op)
			pfs_pkg::OP_TICK: res.wr_en = loaded && (count != pfs_pkg::COUNT_MAX);
			pfs_pkg::OP_ACK:  res.wr_en = res.due;
			default:          res.wr_en = 1'b0;
		endcase
	end

endmodule

@@ src/pfs_out_reg.sv @@
// ----------------------------------------------------------------------------
// pfs_out_reg: result output register
// Holds one poll result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pfs_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  pfs_pkg::result_t            push_data,
	output logic                        free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // [3:0] due_slot, [7:4] zero
	output logic                        m_tuser,  // [0] due_valid
	output logic                        m_tlast
);

	logic             valid_q;
	pfs_pkg::result_t data_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			data_q <= push_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0000, data_q.due_slot};
	assign m_tuser  = data_q.due_valid;
	assign m_tlast  = data_q.last_of_run;

endmodule

@@ src/periodic_frame_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_frame_scheduler: periodic frame slot scheduler
// Slot table with intervals and elapsed counters, scanned by one shared unit.
// ----------------------------------------------------------------------------
// usage:
// - input channel s_*: one transaction per command; s_tuser carries the op
//   (tick, poll, ack, load), s_tdata the slot index, interval and start count
// - output channel m_*: poll results; m_tdata holds the due slot, m_tuser the
//   due-valid flag, m_tlast marks the final result of a poll
// - load is written as it is accepted; ack passes through the ACK state
//   (read-compare-subtract through the unit); tick and poll walk the slots one
//   per cycle through the shared unit, a poll only while the output register
//   can take its results; s_tready stays low for the scan and, for a poll, until the closing result is emitted
// - s_tready is high only while the sequencer is idle
// - a poll emits one result per due slot in ascending order; a due slot is
//   held one step so the last one can be marked with m_tlast; with nothing
//   due one result with m_tuser low and m_tlast high is sent
// - when the receiver stalls, the output register keeps its transaction and
//   the scan waits at the next due slot until the register frees up
// - reset clears the loaded flags and the sequencer; intervals and counters
//   are not reset and are only read for loaded slots
// ----------------------------------------------------------------------------
module periodic_frame_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [3:0] slot_index, [19:4] interval_value,
	                              // [35:20] start_count, [39:36] zero
	input  logic [1:0]  s_tuser,  // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [3:0] due_slot, [7:4] zero
	output logic        m_tuser,  // [0] due_valid
	output logic        m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_ACK
	} state_t;

	localparam logic [pfs_pkg::SLOT_W:0]   SLOT_LIMIT = (pfs_pkg::SLOT_W + 1)'(pfs_pkg::NUM_SLOTS);
	localparam logic [pfs_pkg::SLOT_W-1:0] SLOT_LAST  =
		pfs_pkg::SLOT_W'(pfs_pkg::NUM_SLOTS - 1);

	// slot table, intervals and counters undefined until a load
	logic [pfs_pkg::CNT_W-1:0]        interval_q [pfs_pkg::NUM_SLOTS];
	logic signed [pfs_pkg::CNT_W-1:0] count_q    [pfs_pkg::NUM_SLOTS];
	logic [pfs_pkg::NUM_SLOTS-1:0]    loaded_q;

	state_t                    state_q;
	pfs_pkg::op_t              op_q;
	logic [pfs_pkg::SLOT_W-1:0] idx_q;
	logic                      held_valid_q;
	logic [pfs_pkg::SLOT_W-1:0] held_slot_q;

	pfs_pkg::op_t              in_op;
	logic [pfs_pkg::SLOT_W-1:0] in_slot;
	logic                      in_slot_ok;
	logic                      in_fire;

	pfs_pkg::alu_res_t         alu_res;
	logic                      out_free;
	logic                      push;
	pfs_pkg::result_t          push_data;
	logic                      is_poll_scan;
	logic                      scan_stall;
	logic                      scan_done;

	assign in_op      = pfs_pkg::op_t'(s_tuser);
	assign in_slot    = s_tdata[3:0];
	assign in_slot_ok = ({1'b0, in_slot} < SLOT_LIMIT);
	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;

	// shared unit sees the slot under the sequencer's index
	pfs_alu u_alu (
		.op       (op_q),
		.loaded   (loaded_q[idx_q]),
		.interval (interval_q[idx_q]),
		.count    (count_q[idx_q]),
		.res      (alu_res)
	);

	// a due slot found while another is held pushes the held one out
	assign is_poll_scan = (state_q == ST_SCAN) && (op_q == pfs_pkg::OP_POLL);
	assign scan_stall   = is_poll_scan && alu_res.due && held_valid_q && !out_free;
	assign scan_done    = (idx_q == SLOT_LAST);

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (is_poll_scan && alu_res.due && held_valid_q) begin
			push               = out_free;
			push_data.due_slot  = held_slot_q;
			push_data.due_valid = 1'b1;
		end else if (state_q == ST_FLUSH) begin
			push                  = out_free;
			push_data.due_slot    = held_valid_q ? held_slot_q : '0;
			push_data.due_valid   = held_valid_q;
			push_data.last_of_run = 1'b1;
		end
	end

	pfs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= pfs_pkg::OP_TICK;
			idx_q        <= '0;
			held_valid_q <= 1'b0;
			loaded_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q <= in_op;
						unique case (in_op)
							pfs_pkg::OP_TICK,
							pfs_pkg::OP_POLL: begin
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
							pfs_pkg::OP_ACK: begin
								idx_q <= in_slot;
								if (in_slot_ok) begin
									state_q <= ST_ACK;
								end
							end
							pfs_pkg::OP_LOAD: begin
								if (in_slot_ok) begin
									loaded_q[in_slot] <= 1'b1;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (is_poll_scan && alu_res.due) begin
							held_valid_q <= 1'b1;
						end
						if (scan_done) begin
							state_q <= (op_q == pfs_pkg::OP_POLL) ? ST_FLUSH : ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_ACK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// held due slot and table writes
	always_ff @(posedge clk) begin
		if (is_poll_scan && alu_res.due && !scan_stall) begin
			held_slot_q <= idx_q;
		end
		if (in_fire && in_op == pfs_pkg::OP_LOAD && in_slot_ok) begin
			interval_q[in_slot] <= s_tdata[19:4];
			count_q[in_slot]    <= $signed(s_tdata[35:20]);
		end else if (((state_q == ST_SCAN && op_q == pfs_pkg::OP_TICK) ||
		              state_q == ST_ACK) && alu_res.wr_en) begin
			count_q[idx_q] <= alu_res.next_count;
		end
	end

endmodule
